// ----- rtl/core/qrb_pkg.sv -----
// ----------------------------------------------------------------------------
// qrb_pkg
// Shared types and constants for the quadratic residue bitstring block.
// ----------------------------------------------------------------------------
package qrb_pkg;

  localparam int MAX_MODULUS = 4096;
  localparam int MOD_W       = 13;
  localparam int WORD_W      = 64;
  localparam int ADDR_W      = 12;
  localparam int BIT_W       = 6;
  localparam int WADDR_W     = ADDR_W - BIT_W;
  localparam int NWORDS      = MAX_MODULUS / WORD_W;
  localparam int NBITS_W     = 7;
  localparam int HALF_W      = ADDR_W - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CLEAR,
    S_MARK,
    S_READ,
    S_LOAD,
    S_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic wc_clr;
    logic wc_inc;
    logic clr_wr;
    logic mark_init;
    logic mark_step;
    logic rd_issue;
    logic out_load;
    logic out_spec;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic clr_done;
    logic mark_done;
    logic taken;
    logic out_last;
  } sts_t;

endpackage

// ----- rtl/core/qrb_datapath.sv -----
// ----------------------------------------------------------------------------
// qrb_datapath
// Modulus register, square stepper, residue bitmap and output word register.
// ----------------------------------------------------------------------------
module qrb_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  qrb_pkg::cmd_t                    cmd,
  output qrb_pkg::sts_t                    sts,
  input  logic [qrb_pkg::MOD_W-1:0]        in_modulus,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [qrb_pkg::WORD_W-1:0]       out_bit_word,
  output logic [qrb_pkg::NBITS_W-1:0]      out_valid_bits,
  output logic                             out_last_word,
  output logic                             out_impossible
);

  logic [qrb_pkg::MOD_W-1:0]   p_r;
  logic [qrb_pkg::WADDR_W-1:0] wc_r;
  logic [qrb_pkg::HALF_W-1:0]  i_r;
  logic [qrb_pkg::ADDR_W-1:0]  sq_r;
  logic [qrb_pkg::MOD_W-1:0]   d_r;
  logic [qrb_pkg::WORD_W-1:0]  rd_r;
  logic [qrb_pkg::WORD_W-1:0]  mem [qrb_pkg::NWORDS];

  logic                        out_valid_r;
  logic [qrb_pkg::WORD_W-1:0]  out_word_r;
  logic [qrb_pkg::NBITS_W-1:0] out_nbits_r;
  logic                        out_last_r;
  logic                        out_imp_r;

  logic [qrb_pkg::ADDR_W-1:0]  n12;
  logic [qrb_pkg::ADDR_W-1:0]  nm1;
  logic [qrb_pkg::WADDR_W-1:0] lastw;
  logic [qrb_pkg::NBITS_W-1:0] last_nbits;
  logic [qrb_pkg::HALF_W-1:0]  half;
  logic [qrb_pkg::MOD_W-1:0]   sq_sum;
  logic [qrb_pkg::ADDR_W-1:0]  sq_nxt;
  logic [qrb_pkg::ADDR_W-1:0]  mi;
  logic [qrb_pkg::NBITS_W-1:0] nbits_nxt;
  logic [qrb_pkg::WORD_W-1:0]  word_nxt;
  logic                        imp;
  logic                        taken;

  assign n12        = qrb_pkg::ADDR_W'(p_r - qrb_pkg::MOD_W'(1));
  assign nm1        = n12 - qrb_pkg::ADDR_W'(1);
  assign lastw      = nm1[qrb_pkg::ADDR_W-1:qrb_pkg::BIT_W];
  assign last_nbits = {1'b0, nm1[qrb_pkg::BIT_W-1:0]} + qrb_pkg::NBITS_W'(1);
  assign half       = n12[qrb_pkg::ADDR_W-1:1];
  assign imp        = (p_r >= qrb_pkg::MOD_W'(2));
  assign mi         = sq_r - qrb_pkg::ADDR_W'(1);

  assign sq_sum = {1'b0, sq_r} + d_r;
  assign sq_nxt = (sq_sum >= p_r) ? qrb_pkg::ADDR_W'(sq_sum - p_r)
                                  : qrb_pkg::ADDR_W'(sq_sum);

  assign nbits_nxt = (wc_r == lastw) ? last_nbits : qrb_pkg::NBITS_W'(qrb_pkg::WORD_W);

  always_comb begin
    for (int j = 0; j < qrb_pkg::WORD_W; j++) begin
      word_nxt[j] = (qrb_pkg::NBITS_W'(j) < nbits_nxt) & ~rd_r[j];
    end
  end

  assign taken = out_valid_r & ~out_stall;

  assign sts.special   = (p_r == qrb_pkg::MOD_W'(2)) || (p_r < qrb_pkg::MOD_W'(2)) ||
                         (p_r > qrb_pkg::MOD_W'(qrb_pkg::MAX_MODULUS));
  assign sts.clr_done  = (wc_r == lastw);
  assign sts.mark_done = (i_r == half);
  assign sts.taken     = taken;
  assign sts.out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r <= in_modulus;
    end
    if (cmd.wc_clr) begin
      wc_r <= '0;
    end else if (cmd.wc_inc) begin
      wc_r <= wc_r + qrb_pkg::WADDR_W'(1);
    end
    if (cmd.mark_init) begin
      i_r  <= qrb_pkg::HALF_W'(1);
      sq_r <= qrb_pkg::ADDR_W'(1);
      d_r  <= qrb_pkg::MOD_W'(3);
    end else if (cmd.mark_step) begin
      i_r  <= i_r + qrb_pkg::HALF_W'(1);
      sq_r <= sq_nxt;
      d_r  <= d_r + qrb_pkg::MOD_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[wc_r] <= '0;
    end else if (cmd.mark_step && (sq_r != '0)) begin
      mem[mi[qrb_pkg::ADDR_W-1:qrb_pkg::BIT_W]][mi[qrb_pkg::BIT_W-1:0]] <= 1'b1;
    end
    if (cmd.rd_issue) begin
      rd_r <= mem[wc_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load || cmd.out_spec) begin
      out_valid_r <= 1'b1;
    end else if (taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_spec) begin
      out_word_r  <= '0;
      out_nbits_r <= '0;
      out_last_r  <= 1'b1;
      out_imp_r   <= imp;
    end else if (cmd.out_load) begin
      out_word_r  <= word_nxt;
      out_nbits_r <= nbits_nxt;
      out_last_r  <= (wc_r == lastw);
      out_imp_r   <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bit_word   = out_word_r;
  assign out_valid_bits = out_nbits_r;
  assign out_last_word  = out_last_r;
  assign out_impossible = out_imp_r;

`ifndef ASSERT_OFF
  a_imp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_imp_r |-> out_last_r && out_word_r == '0)
    else $error("impossible beat not marked last or carries bits");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_nbits_r == qrb_pkg::NBITS_W'(qrb_pkg::WORD_W))
    else $error("non-final beat is not a full word");

  a_sq_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_step |-> sq_r < p_r)
    else $error("square index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !taken |-> !cmd.out_load && !cmd.out_spec)
    else $error("output register overwritten before it was taken");
`endif

endmodule

// ----- rtl/core/qrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// qrb_ctrl
// Sequencer: clear the bitmap, mark the squares, read out word by word, or send one special beat.
// ----------------------------------------------------------------------------
module qrb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qrb_pkg::sts_t sts,
  output qrb_pkg::cmd_t cmd
);

  qrb_pkg::state_t state_r;
  qrb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qrb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      qrb_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cmd.wc_clr = 1'b1;
          state_nxt  = qrb_pkg::S_START;
        end
      end
      qrb_pkg::S_START: begin
        if (sts.special) begin
          cmd.out_spec = 1'b1;
          state_nxt    = qrb_pkg::S_SEND;
        end else begin
          state_nxt = qrb_pkg::S_CLEAR;
        end
      end
      qrb_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          cmd.mark_init = 1'b1;
          cmd.wc_clr    = 1'b1;
          state_nxt     = qrb_pkg::S_MARK;
        end else begin
          cmd.wc_inc = 1'b1;
        end
      end
      qrb_pkg::S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_done) begin
          state_nxt = qrb_pkg::S_READ;
        end
      end
      qrb_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = qrb_pkg::S_LOAD;
      end
      qrb_pkg::S_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = qrb_pkg::S_SEND;
      end
      qrb_pkg::S_SEND: begin
        if (sts.taken) begin
          if (sts.out_last) begin
            state_nxt = qrb_pkg::S_IDLE;
          end else begin
            cmd.wc_inc = 1'b1;
            state_nxt  = qrb_pkg::S_READ;
          end
        end
      end
      default: begin
        state_nxt = qrb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/quadratic_residue_bitstring_top.sv -----
// ----------------------------------------------------------------------------
// quadratic_residue_bitstring_top
// Legendre sequence generator: residue bitmap per modulus, read out in words.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one modulus p per beat (valid/stall). The out_
//   channel returns ceil((p-1)/64) beats of 64 sequence bits, LSB first,
//   with out_valid_bits and out_last_word on the final beat. Moduli 0 and 1
//   give one empty final beat; 2 or above 4096 give one beat with
//   out_impossible set.
//   Operation: with W = ceil((p-1)/64) and H = (p-1)/2 the block clears
//   W bitmap words, marks H squares at one square per cycle, then for
//   each word reads the bitmap and loads the output register.
//   One modulus is in work at a time: in_stall is high from acceptance
//   until the final beat is taken.
//   A stall on out_stall holds the current beat and the whole sequencer.
//   After reset the block is idle and ready; the bitmap needs no clearing
//   pass as each item clears the words it uses.
// ----------------------------------------------------------------------------
module quadratic_residue_bitstring_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [qrb_pkg::MOD_W-1:0]        in_modulus,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [qrb_pkg::WORD_W-1:0]       out_bit_word,
  output logic [qrb_pkg::NBITS_W-1:0]      out_valid_bits,
  output logic                             out_last_word,
  output logic                             out_impossible
);

  qrb_pkg::cmd_t cmd;
  qrb_pkg::sts_t sts;

  qrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qrb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_modulus     (in_modulus),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bit_word   (out_bit_word),
    .out_valid_bits (out_valid_bits),
    .out_last_word  (out_last_word),
    .out_impossible (out_impossible)
  );

endmodule
